### src/pws_pkg.sv
// ----------------------------------------------------------------------------
// pws_pkg
// Shared types and constants for the parallel WS2812 serializer: command
// codes, register indexes, register defaults and the pixel write request.
// ----------------------------------------------------------------------------
package pws_pkg;

    // Command codes of an input request
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_SET   = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    // Configuration register indexes
    localparam int          CFG_IDX_W           = 3;
    localparam logic [2:0]  CFG_BIT_PERIOD_LAST = 3'd0;
    localparam logic [2:0]  CFG_DATA_PHASE      = 3'd1;
    localparam logic [2:0]  CFG_LOW_PHASE       = 3'd2;
    localparam logic [2:0]  CFG_DEAD_PERIODS    = 3'd3;
    localparam logic [2:0]  CFG_LED_COUNT       = 3'd4;
    localparam int          CFG_DATA_W          = 8;

    // Bits sent per LED (green, red, blue, MSB first)
    localparam int          COLOR_BITS    = 24;
    localparam logic [4:0]  LAST_COLOR_BIT = 5'd23;

    // Default geometry
    localparam int          DEF_LANES = 16;
    localparam int          DEF_LEDS  = 16;
    localparam int          PINS_W    = 16;

    typedef struct packed {
        logic [7:0] bit_period_last;
        logic [7:0] data_phase;
        logic [7:0] low_phase;
        logic [7:0] dead_periods;
        logic [4:0] led_count;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        bit_period_last: 8'd29,
        data_phase:      8'd8,
        low_phase:       8'd17,
        dead_periods:    8'd19,
        led_count:       5'd16
    };

    // One lane's colour written into one LED position
    typedef struct packed {
        logic       en;
        logic [3:0] lane;
        logic [3:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix_wr;

endpackage

### src/pws_frame_store.sv
// ----------------------------------------------------------------------------
// pws_frame_store
// Frame memory, one row per LED position holding every lane's 24-bit colour.
// Clears itself after reset, prefetches the next row every cycle and keeps
// the row in use in a register, both kept coherent with pixel writes.
// ----------------------------------------------------------------------------
module pws_frame_store
    import pws_pkg::*;
#(
    parameter int LANES = DEF_LANES,
    parameter int LEDS  = DEF_LEDS,
    localparam int LED_W  = (LEDS > 1) ? $clog2(LEDS) : 1,
    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_pix_wr                           i_wr,
    input  logic [LED_W-1:0]                  i_rd_addr,
    input  logic [LED_W-1:0]                  i_cur_led,
    input  logic                              i_row_load,
    output logic [LANES-1:0][COLOR_BITS-1:0]  o_row,
    output logic                              o_ready
);

    logic [LANES-1:0][COLOR_BITS-1:0] mem [LEDS];

    logic                             r_clearing;
    logic [LED_W-1:0]                 r_clr_addr;
    logic [LANES-1:0][COLOR_BITS-1:0] r_next;
    logic [LANES-1:0][COLOR_BITS-1:0] r_row;

    logic                  pix_ok;
    logic [LED_W-1:0]      pix_row;
    logic [LANE_W-1:0]     pix_lane;
    logic [COLOR_BITS-1:0] pix_colour;

    assign pix_ok = i_wr.en
                  && ({1'b0, i_wr.lane} < 5'(LANES))
                  && (11'(i_wr.led_index) < 11'(LEDS));
    assign pix_row    = LED_W'(i_wr.led_index);
    assign pix_lane   = LANE_W'(i_wr.lane);
    assign pix_colour = {i_wr.green, i_wr.red, i_wr.blue};

    // Clearing sweep, one row per cycle after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == LED_W'(LEDS - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr_addr] <= '0;
        end else if (pix_ok) begin
            mem[pix_row][pix_lane] <= pix_colour;
        end
    end

    // Prefetch; forward a write that lands on the row being read
    always_ff @(posedge i_clk) begin
        r_next <= mem[i_rd_addr];
        if (r_clearing && (r_clr_addr == i_rd_addr)) begin
            r_next <= '0;
        end else if (pix_ok && (pix_row == i_rd_addr)) begin
            r_next[pix_lane] <= pix_colour;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_row_load) begin
            r_row <= r_next;
        end else if (pix_ok && (pix_row == i_cur_led)) begin
            r_row[pix_lane] <= pix_colour;
        end
    end

    assign o_row   = r_row;
    assign o_ready = !r_clearing;

endmodule

### src/pws_engine.sv
// ----------------------------------------------------------------------------
// pws_engine
// Waveform sequencer: phase, bit, LED and gap counters, the frame mode and
// the pin levels. Works on one request per fire.
// ----------------------------------------------------------------------------
module pws_engine
    import pws_pkg::*;
#(
    parameter int LANES = DEF_LANES,
    parameter int LEDS  = DEF_LEDS,
    localparam int LED_W = (LEDS > 1) ? $clog2(LEDS) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_fire,
    input  logic [1:0]                        i_cmd,
    input  t_cfg                              i_cfg,
    input  logic [LANES-1:0][COLOR_BITS-1:0]  i_row,
    output logic [LED_W-1:0]                  o_rd_addr,
    output logic [LED_W-1:0]                  o_cur_led,
    output logic                              o_row_load,
    output logic [LANES-1:0]                  o_pins,
    output logic                              o_busy,
    output logic                              o_done
);

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_DATA = 2'd1;
    localparam logic [1:0] MODE_GAP  = 2'd2;

    localparam int CW_A = (LEDS > 1) ? $clog2(LEDS + 1) : 1;
    localparam int CW   = (CW_A > 5) ? CW_A : 5;

    logic [1:0]       r_mode,  n_mode;
    logic [7:0]       r_phase, n_phase;
    logic [7:0]       r_gap,   n_gap;
    logic [4:0]       r_bit,   n_bit;
    logic [LED_W-1:0] r_led,   n_led;
    logic [LANES-1:0] r_pins,  n_pins;

    logic             period_end;
    logic             data_end;
    logic             done;
    logic             row_load;
    logic [CW-1:0]    leds_sent;
    logic [CW-1:0]    led_ext;
    logic [LANES-1:0] data_word;
    logic [4:0]       col_bit;

    assign leds_sent = (CW'(i_cfg.led_count) > CW'(LEDS)) ? CW'(LEDS) : CW'(i_cfg.led_count);
    assign led_ext   = CW'(r_led);
    assign col_bit   = LAST_COLOR_BIT - r_bit;

    // Data part ends when the bit count reaches leds_sent * 24
    assign data_end = (r_bit == LAST_COLOR_BIT) ? ((led_ext + 1'b1) >= leds_sent)
                                                : (led_ext >= leds_sent);
    assign period_end = (r_phase >= i_cfg.bit_period_last);

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            data_word[l] = i_row[l][col_bit];
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_phase  = r_phase;
        n_gap    = r_gap;
        n_bit    = r_bit;
        n_led    = r_led;
        n_pins   = r_pins;
        done     = 1'b0;
        row_load = 1'b0;
        if (i_fire) begin
            unique case (i_cmd)
                CMD_TICK: begin
                    unique case (r_mode)
                        MODE_DATA: begin
                            // high, data, low: a later event on the same phase wins
                            if (r_phase == 8'd0) begin
                                n_pins = '1;
                            end
                            if (r_phase == i_cfg.data_phase) begin
                                n_pins = data_word;
                            end
                            if (r_phase == i_cfg.low_phase) begin
                                n_pins = '0;
                            end
                            if (period_end) begin
                                n_phase = 8'd0;
                                if (data_end) begin
                                    n_mode = MODE_GAP;
                                    n_gap  = 8'd0;
                                end else if (r_bit == LAST_COLOR_BIT) begin
                                    n_bit    = 5'd0;
                                    n_led    = r_led + 1'b1;
                                    row_load = 1'b1;
                                end else begin
                                    n_bit = r_bit + 5'd1;
                                end
                            end else begin
                                n_phase = r_phase + 8'd1;
                            end
                        end
                        MODE_GAP: begin
                            n_pins = '0;
                            if (period_end) begin
                                n_phase = 8'd0;
                                if (r_gap >= i_cfg.dead_periods) begin
                                    n_mode = MODE_IDLE;
                                    n_gap  = 8'd0;
                                    done   = 1'b1;
                                end else begin
                                    n_gap = r_gap + 8'd1;
                                end
                            end else begin
                                n_phase = r_phase + 8'd1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                CMD_START: begin
                    // ignore start while busy
                    if (r_mode == MODE_IDLE) begin
                        n_bit    = 5'd0;
                        n_led    = '0;
                        n_phase  = 8'd0;
                        n_gap    = 8'd0;
                        n_mode   = (leds_sent == '0) ? MODE_GAP : MODE_DATA;
                        row_load = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_phase <= 8'd0;
            r_gap   <= 8'd0;
            r_bit   <= 5'd0;
            r_led   <= '0;
            r_pins  <= '0;
        end else begin
            r_mode  <= n_mode;
            r_phase <= n_phase;
            r_gap   <= n_gap;
            r_bit   <= n_bit;
            r_led   <= n_led;
            r_pins  <= n_pins;
        end
    end

    // Prefetch the following LED while sending, row 0 otherwise
    assign o_rd_addr  = (r_mode == MODE_DATA) ? r_led + 1'b1 : '0;
    assign o_cur_led  = r_led;
    assign o_row_load = row_load;
    assign o_pins     = n_pins;
    assign o_busy     = (n_mode != MODE_IDLE);
    assign o_done     = done;

endmodule

### src/parallel_ws2812_serializer.sv
// ----------------------------------------------------------------------------
// parallel_ws2812_serializer
// Drives up to LANES WS2812 strips in parallel from a per-LED frame memory.
// ----------------------------------------------------------------------------
// One request is taken every clock while input is not stalled; each tick
// request advances the bit waveform by one phase. Requests move through an
// input register, the sequencer and a result register; a waiting result
// holds the request in the input register, and input stalls while that is
// full. The frame memory holds one row per LED position; the row in use and
// the next one are kept in registers, the next one prefetched ahead of the
// LED boundary. After reset the memory is cleared, during which input stays
// stalled; configuration writes are taken at any time.
module parallel_ws2812_serializer
    import pws_pkg::*;
#(
    parameter int LANES = DEF_LANES,
    parameter int LEDS  = DEF_LEDS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_cmd,
    input  logic [3:0]            i_lane,
    input  logic [3:0]            i_led_index,
    input  logic [7:0]            i_red,
    input  logic [7:0]            i_green,
    input  logic [7:0]            i_blue,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [PINS_W-1:0]     o_pins,
    output logic                  o_busy_res,
    output logic                  o_frame_done
);

    localparam int LED_W = (LEDS > 1) ? $clog2(LEDS) : 1;

    t_cfg             r_cfg;
    logic             r_in_valid;
    logic [1:0]       r_in_cmd;
    logic [3:0]       r_in_lane;
    logic [3:0]       r_in_led;
    logic [7:0]       r_in_red;
    logic [7:0]       r_in_green;
    logic [7:0]       r_in_blue;
    logic             r_out_valid;
    logic [LANES-1:0] r_out_pins;
    logic             r_out_busy;
    logic             r_out_done;

    logic                             store_ready;
    logic                             accept_in;
    logic                             fire;
    t_pix_wr                          pix_wr;
    logic [LED_W-1:0]                 rd_addr;
    logic [LED_W-1:0]                 cur_led;
    logic                             row_load;
    logic [LANES-1:0][COLOR_BITS-1:0] row;
    logic [LANES-1:0]                 eng_pins;
    logic                             eng_busy;
    logic                             eng_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BIT_PERIOD_LAST: r_cfg.bit_period_last <= i_cfg_data;
                CFG_DATA_PHASE:      r_cfg.data_phase      <= i_cfg_data;
                CFG_LOW_PHASE:       r_cfg.low_phase       <= i_cfg_data;
                CFG_DEAD_PERIODS:    r_cfg.dead_periods    <= i_cfg_data;
                CFG_LED_COUNT:       r_cfg.led_count       <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    // Advance the held request when the result register is free or draining
    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = !store_ready || (r_in_valid && !fire);
    assign accept_in  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept_in) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_in_cmd   <= i_cmd;
            r_in_lane  <= i_lane;
            r_in_led   <= i_led_index;
            r_in_red   <= i_red;
            r_in_green <= i_green;
            r_in_blue  <= i_blue;
        end
    end

    always_comb begin
        pix_wr.en        = fire && (r_in_cmd == CMD_SET);
        pix_wr.lane      = r_in_lane;
        pix_wr.led_index = r_in_led;
        pix_wr.red       = r_in_red;
        pix_wr.green     = r_in_green;
        pix_wr.blue      = r_in_blue;
    end

    pws_frame_store #(
        .LANES (LANES),
        .LEDS  (LEDS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (pix_wr),
        .i_rd_addr  (rd_addr),
        .i_cur_led  (cur_led),
        .i_row_load (row_load),
        .o_row      (row),
        .o_ready    (store_ready)
    );

    pws_engine #(
        .LANES (LANES),
        .LEDS  (LEDS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_cmd      (r_in_cmd),
        .i_cfg      (r_cfg),
        .i_row      (row),
        .o_rd_addr  (rd_addr),
        .o_cur_led  (cur_led),
        .o_row_load (row_load),
        .o_pins     (eng_pins),
        .o_busy     (eng_busy),
        .o_done     (eng_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_pins <= eng_pins;
            r_out_busy <= eng_busy;
            r_out_done <= eng_done;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pins       = PINS_W'(r_out_pins);
    assign o_busy_res   = r_out_busy;
    assign o_frame_done = r_out_done;

endmodule

### tb/pws_checker.sv
// ----------------------------------------------------------------------------
// pws_checker
// Watches the request, result and register ports of the parallel WS2812
// serializer, forecasts pin levels, busy and frame-done for every request
// and compares them with what the block reports, oldest first.
// ----------------------------------------------------------------------------
module pws_checker
    import pws_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [1:0]            i_cmd,
    input  logic [3:0]            i_lane,
    input  logic [3:0]            i_led_index,
    input  logic [7:0]            i_red,
    input  logic [7:0]            i_green,
    input  logic [7:0]            i_blue,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [PINS_W-1:0]     i_pins,
    input  logic                  i_busy_res,
    input  logic                  i_frame_done,
    output int                    o_errors,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int              N_LANES     = DEF_LANES;
    localparam int              N_LEDS      = DEF_LEDS;
    localparam int              STORE_WORDS = N_LEDS * COLOR_BITS;
    localparam logic [PINS_W-1:0] LANE_ALL  = PINS_W'((1 << N_LANES) - 1);

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_DATA,
        SEQ_GAP
    } t_seq;

    typedef struct packed {
        logic [PINS_W-1:0] pins;
        logic              busy;
        logic              done;
    } t_pin_report;

    logic [PINS_W-1:0] plane [STORE_WORDS];
    logic [8:0]        bit_idx;
    logic [7:0]        phase;
    logic [7:0]        gap_idx;
    t_seq              seq;
    logic [PINS_W-1:0] level;
    t_cfg              cfg;
    t_pin_report       forecast_q [$];
    int                fault_count = 0;
    int                waiting     = 0;

    assign o_errors  = fault_count;
    assign o_pending = waiting;

    function automatic int unsigned frame_bits();
        int unsigned n;
        n = cfg.led_count;
        if (n > N_LEDS) n = N_LEDS;
        return n * COLOR_BITS;
    endfunction

    function automatic void paint_pixel(logic [3:0] lane, logic [3:0] led,
                                        logic [7:0] r, logic [7:0] g, logic [7:0] b);
        logic [COLOR_BITS-1:0] colour;
        colour = {g, r, b};
        if (lane < N_LANES && led < N_LEDS) begin
            for (int k = 0; k < COLOR_BITS; k++) begin
                plane[led * COLOR_BITS + k][lane] = colour[COLOR_BITS - 1 - k];
            end
        end
    endfunction

    // One clock of the bit waveform; returns 1 when the latch gap ends.
    function automatic logic waveform_tick();
        logic       done;
        logic       last;
        logic [7:0] p;
        done = 1'b0;
        p    = phase;
        last = (p >= cfg.bit_period_last);
        case (seq)
            SEQ_DATA: begin
                // later events on the same phase win: high, then data, then low
                if (p == 8'd0) level = LANE_ALL;
                if (p == cfg.data_phase)
                    level = (bit_idx < STORE_WORDS) ? (plane[bit_idx] & LANE_ALL) : '0;
                if (p == cfg.low_phase) level = '0;
                if (last) begin
                    phase   = '0;
                    bit_idx = bit_idx + 9'd1;
                    if (bit_idx >= frame_bits()) begin
                        seq     = SEQ_GAP;
                        gap_idx = '0;
                    end
                end else begin
                    phase = p + 8'd1;
                end
            end
            SEQ_GAP: begin
                level = '0;
                if (last) begin
                    phase = '0;
                    if (gap_idx >= cfg.dead_periods) begin
                        seq     = SEQ_IDLE;
                        gap_idx = '0;
                        done    = 1'b1;
                    end else begin
                        gap_idx = gap_idx + 8'd1;
                    end
                end else begin
                    phase = p + 8'd1;
                end
            end
            default: ;
        endcase
        return done;
    endfunction

    function automatic t_pin_report serialize_step(logic [1:0] cmd, logic [3:0] lane,
                                                   logic [3:0] led, logic [7:0] r,
                                                   logic [7:0] g, logic [7:0] b);
        t_pin_report rep;
        logic        done;
        done = 1'b0;
        case (cmd)
            CMD_TICK:  done = waveform_tick();
            CMD_SET:   paint_pixel(lane, led, r, g, b);
            CMD_START: begin
                // ignore a start while a frame or gap is running
                if (seq == SEQ_IDLE) begin
                    bit_idx = '0;
                    phase   = '0;
                    gap_idx = '0;
                    seq     = (frame_bits() == 0) ? SEQ_GAP : SEQ_DATA;
                end
            end
            default: ;
        endcase
        rep.pins = level;
        rep.busy = (seq != SEQ_IDLE);
        rep.done = done;
        return rep;
    endfunction

    function automatic void note_mismatch(string field, int want, int got);
        fault_count++;
        $display("%0t: %s mismatch, expected %h, actual %h", $realtime, field, want, got);
    endfunction

    always @(posedge i_clk) begin
        t_pin_report want;
        if (!i_rst_n) begin
            for (int w = 0; w < STORE_WORDS; w++) plane[w] = '0;
            bit_idx = '0;
            phase   = '0;
            gap_idx = '0;
            seq     = SEQ_IDLE;
            level   = '0;
            cfg     = CFG_RESET;
            forecast_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (forecast_q.size() == 0) begin
                    fault_count++;
                    $display("%0t: result with none expected, expected none, actual %h %b %b",
                             $realtime, i_pins, i_busy_res, i_frame_done);
                end else begin
                    want = forecast_q.pop_front();
                    if (i_pins !== want.pins) note_mismatch("pins", want.pins, i_pins);
                    if (i_busy_res !== want.busy) note_mismatch("busy_res", want.busy, i_busy_res);
                    if (i_frame_done !== want.done)
                        note_mismatch("frame_done", want.done, i_frame_done);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BIT_PERIOD_LAST: cfg.bit_period_last = i_cfg_data;
                    CFG_DATA_PHASE:      cfg.data_phase      = i_cfg_data;
                    CFG_LOW_PHASE:       cfg.low_phase       = i_cfg_data;
                    CFG_DEAD_PERIODS:    cfg.dead_periods    = i_cfg_data;
                    CFG_LED_COUNT:       cfg.led_count       = i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                forecast_q.push_back(serialize_step(i_cmd, i_lane, i_led_index,
                                                    i_red, i_green, i_blue));
        end
        waiting = forecast_q.size();
    end

endmodule

### tb/tb_parallel_ws2812_serializer.sv
// ----------------------------------------------------------------------------
// tb_parallel_ws2812_serializer
// Drives pixel writes, frame starts and waveform ticks into the serializer
// through bursty requests and a stalling receiver, reprograms the timing
// registers between phases and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb_parallel_ws2812_serializer
    import pws_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         ITEM_TARGET = 1450;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         HOLD_CYCLES = 64;
    localparam int         SETTLE      = 6;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic [1:0]            cmd         = CMD_TICK;
    logic [3:0]            lane        = '0;
    logic [3:0]            led_index   = '0;
    logic [7:0]            red         = '0;
    logic [7:0]            green       = '0;
    logic [7:0]            blue        = '0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic [PINS_W-1:0]     pins;
    logic                  busy_res;
    logic                  frame_done;

    int errors;
    int pending;
    int cycles     = 0;
    int sent       = 0;
    int hold_id    = 0;
    int burst_left = 0;
    int bpl_now    = 29;
    int dead_now   = 19;

    parallel_ws2812_serializer uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_cmd        (cmd),
        .i_lane       (lane),
        .i_led_index  (led_index),
        .i_red        (red),
        .i_green      (green),
        .i_blue       (blue),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_pins       (pins),
        .o_busy_res   (busy_res),
        .o_frame_done (frame_done)
    );

    pws_checker watch (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_cmd        (cmd),
        .i_lane       (lane),
        .i_led_index  (led_index),
        .i_red        (red),
        .i_green      (green),
        .i_blue       (blue),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_pins       (pins),
        .i_busy_res   (busy_res),
        .i_frame_done (frame_done),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_parallel_ws2812_serializer NOT OK");
            $finish;
        end
    end

    // Receiver: rotate between no stall, random stall and a fixed pattern;
    // hold off for a long stretch whenever hold_id moves.
    initial begin
        int         served;
        logic [7:0] pattern;
        served  = 0;
        pattern = 8'b1011_0010;
        forever begin
            @(negedge i_clk);
            if (hold_id != served) begin
                served = hold_id;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            case ((cycles / 250) % 3)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: begin
                    out_stall <= pattern[0];
                    pattern = {pattern[0], pattern[7:1]};
                end
            endcase
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic offer(input logic [1:0] c, input logic [3:0] ln, input logic [3:0] led,
                         input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        in_valid  <= 1'b1;
        cmd       <= c;
        lane      <= ln;
        led_index <= led;
        red       <= r;
        green     <= g;
        blue      <= b;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
        if (c != CMD_UNUSED) sent++;
    endtask

    task automatic offer_tick();
        offer(CMD_TICK, 4'($urandom), 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic offer_random();
        int         roll;
        logic [1:0] c;
        logic [3:0] led;
        roll = $urandom_range(0, 99);
        if (roll < 70)      c = CMD_TICK;
        else if (roll < 85) c = CMD_SET;
        else if (roll < 95) c = CMD_START;
        else                c = CMD_UNUSED;
        // favor the LEDs that short frames actually send
        led = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 2));
        offer(c, 4'($urandom_range(0, 15)), led, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap        = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        burst_left--;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic pick_settings();
        int roll;
        int hi;
        int dp;
        int lp;
        int cnt;
        if ($urandom_range(0, 1)) begin
            roll = $urandom_range(0, 9);
            if (roll < 6)       bpl_now = $urandom_range(1, 5);
            else if (roll == 6) bpl_now = 0;
            else if (roll == 7) bpl_now = $urandom_range(6, 20);
            else if (roll == 8) bpl_now = 255;
            else                bpl_now = $urandom_range(0, 3);
            write_reg(CFG_BIT_PERIOD_LAST, bpl_now);
        end
        hi = (bpl_now > 253) ? 255 : bpl_now + 2;
        dp = $urandom_range(0, hi);
        roll = $urandom_range(0, 7);
        if (roll == 0) dp = 255;
        else if (roll == 1) dp = 0;
        if ($urandom_range(0, 1)) write_reg(CFG_DATA_PHASE, dp);
        lp = $urandom_range(0, hi);
        roll = $urandom_range(0, 7);
        if (roll == 0) lp = 255;
        else if (roll == 1) lp = dp;
        if ($urandom_range(0, 1)) write_reg(CFG_LOW_PHASE, lp);
        if (dead_now == 255 || $urandom_range(0, 1)) begin
            roll = $urandom_range(0, 19);
            if (roll < 12)      dead_now = $urandom_range(0, 2);
            else if (roll < 19) dead_now = $urandom_range(3, 12);
            else                dead_now = 255;
            write_reg(CFG_DEAD_PERIODS, dead_now);
        end
        if ($urandom_range(0, 1)) begin
            roll = $urandom_range(0, 19);
            if (roll < 13)      cnt = $urandom_range(1, 2);
            else if (roll < 15) cnt = 0;
            else if (roll < 19) cnt = $urandom_range(3, 16);
            else                cnt = $urandom_range(17, 31);
            write_reg(CFG_LED_COUNT, cnt);
        end
    endtask

    initial begin
        int  phase_no;
        int  quota;
        bit  calm;
        phase_no = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: pixel corners, unused command, start and start while busy
        offer(CMD_SET, 4'd0, 4'd0, 8'h00, 8'hFF, 8'h80);
        offer(CMD_SET, 4'd15, 4'd15, 8'hFF, 8'h00, 8'h01);
        offer(CMD_SET, 4'd5, 4'd0, 8'hFF, 8'hFF, 8'hFF);
        offer(CMD_SET, 4'd10, 4'd1, 8'h7F, 8'h80, 8'h55);
        offer(CMD_SET, 4'd9, 4'd0, 8'hAA, 8'h01, 8'h00);
        offer(CMD_UNUSED, 4'hF, 4'hF, 8'hFF, 8'hFF, 8'hFF);
        offer(CMD_START, 4'd0, 4'd0, 8'h00, 8'h00, 8'h00);
        offer(CMD_START, 4'hF, 4'hF, 8'hFF, 8'hFF, 8'hFF);
        offer(CMD_SET, 4'd15, 4'd0, 8'h12, 8'h34, 8'h56);
        repeat (12) offer_tick();
        drain();

        // One-tick periods, data on the high phase, low never reached,
        // count above the store clamped; the running frame is cut short mid-period.
        bpl_now  = 0;
        dead_now = 0;
        write_reg(CFG_BIT_PERIOD_LAST, 0);
        write_reg(CFG_DATA_PHASE, 0);
        write_reg(CFG_LOW_PHASE, 255);
        write_reg(CFG_DEAD_PERIODS, 0);
        write_reg(CFG_LED_COUNT, 31);
        for (int k = 0; k < 420; k++) begin
            pace();
            if (k % 37 == 5)
                offer(CMD_SET, 4'($urandom), 4'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom));
            else
                offer_tick();
        end
        drain();

        // Zero LEDs: start goes straight to a long gap; data phase never reached
        bpl_now  = 2;
        dead_now = 255;
        write_reg(CFG_LED_COUNT, 0);
        write_reg(CFG_DEAD_PERIODS, 255);
        write_reg(CFG_BIT_PERIOD_LAST, 2);
        write_reg(CFG_DATA_PHASE, 3);
        write_reg(CFG_LOW_PHASE, 1);
        offer(CMD_START, 4'd0, 4'd0, 8'h00, 8'h00, 8'h00);
        repeat (20) offer_tick();

        while (sent < ITEM_TARGET) begin
            drain();
            pick_settings();
            phase_no++;
            if (phase_no % 5 == 1) hold_id++;
            calm  = (phase_no % 4 == 3);
            quota = $urandom_range(40, 140);
            repeat (quota) begin
                if (!calm) pace();
                offer_random();
            end
        end

        drain();
        if (errors == 0) begin
            $display("tb_parallel_ws2812_serializer OK");
        end else begin
            $display("tb_parallel_ws2812_serializer NOT OK");
        end
        $finish;
    end

endmodule
